// File: src/u8u16_pkg.sv
// Shared types, constants and decode functions of the UTF-8 to UTF-16 transcoder.
`default_nettype none

package u8u16_pkg;

  // Field widths
  localparam int unsigned BYTE_W  = 8;
  localparam int unsigned UNIT_W  = 21;
  localparam int unsigned COUNT_W = 2;

  // Stream and register port widths
  localparam int unsigned S_DATA_W = 8;
  localparam int unsigned M_DATA_W = 24;
  localparam int unsigned APB_DW   = 32;
  localparam int unsigned APB_AW   = 2;

  // Register byte addresses
  localparam logic [APB_AW-1:0] REG_EMIT_UTF32 = 2'd0;

  // Sequence lengths opened by a lead byte
  localparam logic [2:0] LEN_NONE  = 3'd0;
  localparam logic [2:0] LEN_ONE   = 3'd1;
  localparam logic [2:0] LEN_TWO   = 3'd2;
  localparam logic [2:0] LEN_THREE = 3'd3;
  localparam logic [2:0] LEN_FOUR  = 3'd4;

  // Surrogate and plane constants
  localparam logic [UNIT_W-1:0] PLANE1_BASE = 21'h10000;
  localparam logic [15:0]       HI_SURR     = 16'hD800;
  localparam logic [5:0]        LO_SURR_TOP = 6'b110111;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic load;
    logic pop;
  } u8u16_cmd_t;

  // Status from the datapath to the controller
  typedef struct packed {
    logic [COUNT_W-1:0] load_count;
    logic [COUNT_W-1:0] units_left;
  } u8u16_status_t;

  // Length of the sequence a lead byte opens, LEN_NONE for an invalid lead
  function automatic logic [2:0] lead_len(input logic [BYTE_W-1:0] b);
    logic [2:0] n;
    if (b[7] == 1'b0) begin
      n = LEN_ONE;
    end else if (b[7:5] == 3'b110) begin
      n = LEN_TWO;
    end else if (b[7:4] == 4'b1110) begin
      n = LEN_THREE;
    end else if (b[7:3] == 5'b11110) begin
      n = LEN_FOUR;
    end else begin
      n = LEN_NONE;
    end
    return n;
  endfunction

  // Payload bits of a lead byte for a sequence of the given length
  function automatic logic [UNIT_W-1:0] lead_bits(input logic [BYTE_W-1:0] b,
                                                  input logic [2:0] n);
    logic [UNIT_W-1:0] v;
    unique case (n)
      LEN_ONE:   v = {14'd0, b[6:0]};
      LEN_TWO:   v = {16'd0, b[4:0]};
      LEN_THREE: v = {17'd0, b[3:0]};
      default:   v = {18'd0, b[2:0]};
    endcase
    return v;
  endfunction

endpackage

`default_nettype wire

// File: src/u8u16_ctrl.sv
// Controller state machine: takes one byte word, then sends its code unit words.
`default_nettype none

module u8u16_ctrl
  import u8u16_pkg::*;
(
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          s_tvalid,
  output logic               s_tready,
  output logic               m_tvalid,
  input  wire logic          m_tready,
  input  wire u8u16_status_t status,
  output u8u16_cmd_t         cmd
);

  typedef enum logic {
    ST_IDLE,
    ST_SEND
  } state_t;

  state_t state;

  // Load on an accepted byte, drop the head unit on an accepted unit
  assign cmd.load = s_tvalid & s_tready;
  assign cmd.pop  = m_tvalid & m_tready;

  // Hold state and the handshake outputs
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      s_tready <= 1'b0;
      m_tvalid <= 1'b0;
    end else begin
      unique case (state)
        ST_IDLE: begin
          if (cmd.load && (status.load_count != '0)) begin
            state    <= ST_SEND;
            s_tready <= 1'b0;
            m_tvalid <= 1'b1;
          end else begin
            s_tready <= 1'b1;
          end
        end
        ST_SEND: begin
          if (m_tready && (status.units_left == 2'd1)) begin
            state    <= ST_IDLE;
            m_tvalid <= 1'b0;
            s_tready <= 1'b1;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

// File: src/u8u16_datapath.sv
// Datapath: sequence decode state, end-of-string replay and the unit buffer.
`default_nettype none

module u8u16_datapath
  import u8u16_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              emit_utf32,
  input  wire logic [BYTE_W-1:0] in_byte,
  input  wire logic              last_byte,
  input  wire u8u16_cmd_t        cmd,
  output u8u16_status_t          status,
  output logic [UNIT_W-1:0]      code_unit,
  output logic                   last_of_run
);

  // Decode state
  logic [1:0]         bytes_needed, bytes_needed_next;
  logic [UNIT_W-1:0]  code_accum, code_accum_next;
  logic [1:0]         held_count, held_count_next;
  logic [BYTE_W-1:0]  held0;
  logic               held0_we;

  // Unit buffer
  logic [UNIT_W-1:0]  unit0, unit1, unit0_next, unit1_next;
  logic [COUNT_W-1:0] units_left;
  logic [COUNT_W-1:0] load_count;

  logic [2:0]         lead_n;
  logic [UNIT_W-1:0]  accum_shift;
  logic               emit_en;
  logic [UNIT_W-1:0]  emit_cp;
  logic [UNIT_W-1:0]  surr_r;
  logic [15:0]        surr_hi;
  logic               replay_en;
  logic [BYTE_W-1:0]  rp_b0;
  logic               rp_two;
  logic [2:0]         rp_n0;
  logic               rp_a_en, rp_b_en;
  logic [UNIT_W-1:0]  rp_a, rp_b;

  assign lead_n      = lead_len(in_byte);
  assign accum_shift = {code_accum[UNIT_W-7:0], in_byte[5:0]};

  // Advance the sequence state for the incoming byte
  always_comb begin
    bytes_needed_next = bytes_needed;
    code_accum_next   = code_accum;
    held_count_next   = held_count;
    held0_we          = 1'b0;
    emit_en           = 1'b0;
    emit_cp           = accum_shift;
    if (bytes_needed == 2'd0) begin
      if (lead_n == LEN_ONE) begin
        emit_en = 1'b1;
        emit_cp = {13'd0, in_byte};
      end else if (lead_n != LEN_NONE) begin
        code_accum_next   = lead_bits(in_byte, lead_n);
        bytes_needed_next = lead_n[1:0] - 2'd1;
        held_count_next   = 2'd0;
      end
    end else begin
      code_accum_next = accum_shift;
      held0_we        = (held_count == 2'd0);
      if (held_count != 2'd3) begin
        held_count_next = held_count + 2'd1;
      end
      bytes_needed_next = bytes_needed - 2'd1;
      if (bytes_needed_next == 2'd0) begin
        emit_en         = 1'b1;
        held_count_next = 2'd0;
      end
    end
    replay_en = last_byte && (bytes_needed != 2'd0) && (bytes_needed_next != 2'd0);
    // Close any open sequence at the end of the string
    if (last_byte) begin
      bytes_needed_next = 2'd0;
      held_count_next   = 2'd0;
      code_accum_next   = '0;
    end
  end

  // Surrogate pair of the finished code point
  assign surr_r  = emit_cp - PLANE1_BASE;
  assign surr_hi = HI_SURR + {5'd0, surr_r[20:10]};

  // Replay the held bytes as fresh leads: at most two bytes, both below plane 1
  assign rp_b0  = (held_count == 2'd0) ? in_byte : held0;
  assign rp_two = (held_count != 2'd0);
  assign rp_n0  = lead_len(rp_b0);

  always_comb begin
    rp_a_en = 1'b0;
    rp_a    = {13'd0, rp_b0};
    rp_b_en = 1'b0;
    rp_b    = {13'd0, in_byte};
    if (rp_n0 == LEN_ONE) begin
      rp_a_en = 1'b1;
      rp_b_en = rp_two && (lead_n == LEN_ONE);
    end else if ((rp_n0 == LEN_TWO) && rp_two) begin
      rp_a_en = 1'b1;
      rp_a    = {10'd0, rp_b0[4:0], in_byte[5:0]};
    end else begin
      rp_b_en = rp_two && (lead_n == LEN_ONE);
    end
  end

  // Gather the units this byte causes
  always_comb begin
    load_count = 2'd0;
    unit0_next = emit_cp;
    unit1_next = '0;
    if (emit_en) begin
      if (emit_utf32 || (emit_cp < PLANE1_BASE)) begin
        load_count = 2'd1;
      end else begin
        load_count = 2'd2;
        unit0_next = {5'd0, surr_hi};
        unit1_next = {5'd0, LO_SURR_TOP, surr_r[9:0]};
      end
    end else if (replay_en) begin
      if (rp_a_en && rp_b_en) begin
        load_count = 2'd2;
        unit0_next = rp_a;
        unit1_next = rp_b;
      end else if (rp_a_en) begin
        load_count = 2'd1;
        unit0_next = rp_a;
      end else if (rp_b_en) begin
        load_count = 2'd1;
        unit0_next = rp_b;
      end
    end
  end

  // Hold the decode state
  always_ff @(posedge clk) begin
    if (rst) begin
      bytes_needed <= 2'd0;
      code_accum   <= '0;
      held_count   <= 2'd0;
    end else if (cmd.load) begin
      bytes_needed <= bytes_needed_next;
      code_accum   <= code_accum_next;
      held_count   <= held_count_next;
    end
  end

  // Held continuation byte
  always_ff @(posedge clk) begin
    if (cmd.load && held0_we) begin
      held0 <= in_byte;
    end
  end

  // Load the unit buffer, shift it on each sent word
  always_ff @(posedge clk) begin
    if (rst) begin
      units_left <= '0;
    end else if (cmd.load) begin
      units_left <= load_count;
    end else if (cmd.pop && (units_left != '0)) begin
      units_left <= units_left - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      unit0 <= unit0_next;
      unit1 <= unit1_next;
    end else if (cmd.pop) begin
      unit0 <= unit1;
    end
  end

  assign status.load_count = load_count;
  assign status.units_left = units_left;
  assign code_unit         = unit0;
  assign last_of_run       = (units_left == 2'd1);

endmodule

`default_nettype wire

// File: src/utf8_to_utf16_transcoder.sv
// Top level of the UTF-8 to UTF-16 / UTF-32 transcoder with its register port.
//
// Input stream (s_*): one UTF-8 byte per word in s_tdata, s_tlast on the last
// byte of a string. Output stream (m_*): one code unit per word in m_tdata,
// m_tlast on the final unit caused by an input byte.
// Register emit_utf32 at byte address 0: 1 sends whole code points, 0 sends
// UTF-16 units, code points from plane 1 upwards as a surrogate pair.
// Each byte is decoded in the cycle it is taken; its units (none, one or two)
// are then sent one per cycle while the receiver is ready, from a two-entry
// buffer, the first offered in the cycle after the byte is taken. The byte
// closing a plane-1 sequence in UTF-16 mode causes two units. A byte with no
// unit does not hold off the next byte; the controller takes no new byte
// while the buffer still holds units.
// A string ending inside a sequence replays its held bytes as new leads, and
// those units leave in the same burst.
// Reset clears the decode state, the buffer and emit_utf32; s_tready rises in the
// cycle after reset falls. When the receiver stalls, the head unit holds on
// m_tdata and no further byte is accepted.
`default_nettype none

module utf8_to_utf16_transcoder
  import u8u16_pkg::*;
(
  input  wire logic                clk,
  input  wire logic                rst,
  // Byte stream
  input  wire logic                s_tvalid,
  output logic                     s_tready,
  input  wire logic [S_DATA_W-1:0] s_tdata,   // [7:0] in_byte
  input  wire logic                s_tlast,   // last_byte
  // Code unit stream
  output logic                     m_tvalid,
  input  wire logic                m_tready,
  output logic [M_DATA_W-1:0]      m_tdata,   // [20:0] code_unit, [23:21] zero
  output logic                     m_tlast,   // last_of_run
  // Register port
  input  wire logic                psel,
  input  wire logic                penable,
  input  wire logic                pwrite,
  input  wire logic [APB_AW-1:0]   paddr,
  input  wire logic [APB_DW-1:0]   pwdata,
  output logic [APB_DW-1:0]        prdata,
  output logic                     pready
);

  logic              emit_utf32;
  u8u16_cmd_t        cmd;
  u8u16_status_t     status;
  logic [UNIT_W-1:0] code_unit;

  // Register writes and reads
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      emit_utf32 <= 1'b0;
    end else if (psel && penable && pwrite && pready && (paddr == REG_EMIT_UTF32)) begin
      emit_utf32 <= pwdata[0];
    end
  end

  assign prdata = (paddr == REG_EMIT_UTF32) ? {{(APB_DW-1){1'b0}}, emit_utf32} : '0;

  u8u16_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .status   (status),
    .cmd      (cmd)
  );

  u8u16_datapath u_datapath (
    .clk         (clk),
    .rst         (rst),
    .emit_utf32  (emit_utf32),
    .in_byte     (s_tdata),
    .last_byte   (s_tlast),
    .cmd         (cmd),
    .status      (status),
    .code_unit   (code_unit),
    .last_of_run (m_tlast)
  );

  assign m_tdata = {{(M_DATA_W-UNIT_W){1'b0}}, code_unit};

endmodule

`default_nettype wire

// File: src/u8u16_checker.sv
// Port checker of the transcoder and its binding to the top level.
`default_nettype none

module u8u16_checker
  import u8u16_pkg::*;
(
  input wire logic                clk,
  input wire logic                rst,
  input wire logic                s_tready,
  input wire logic                m_tvalid,
  input wire logic                m_tready,
  input wire logic [M_DATA_W-1:0] m_tdata,
  input wire logic                m_tlast
);

  // A stalled word holds
  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
    else $error("stalled code unit word changed");

  // No byte is taken while units are pending
  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    !(s_tready && m_tvalid))
    else $error("byte accepted while units pending");

  // A unit that is not the last of its run is followed by another
  a_run_continues: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tready && !m_tlast |=> m_tvalid)
    else $error("run ended without a last unit");

  // Padding above the code unit stays zero
  a_pad_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tdata[M_DATA_W-1:UNIT_W] == '0))
    else $error("padding bits set");

  // Reset empties the output
  a_reset_idle: assert property (@(posedge clk)
    rst |=> !m_tvalid && !s_tready)
    else $error("output not idle after reset");

endmodule

bind utf8_to_utf16_transcoder u8u16_checker u_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tlast  (m_tlast)
);

`default_nettype wire

// File: bench/tb.sv
`timescale 1ns / 100ps
// Testbench for the UTF-8 to UTF-16 / UTF-32 transcoder: directed and random strings, checked unit by unit.
module tb;
  import u8u16_pkg::*;

  localparam int unsigned CYCLE_LIMIT  = 200000;
  localparam int unsigned DRAIN_CYCLES = 8;
  localparam int unsigned HOLD_CYCLES  = 250;

  typedef struct packed {
    logic [UNIT_W-1:0] unit;
    logic              last;
  } code_unit_t;

  // Decoder state, register copy and the queue of units still to come out
  class code_unit_tracker;
    logic              emit_utf32;
    logic [1:0]        bytes_needed;
    logic [UNIT_W-1:0] code_accum;
    logic [BYTE_W-1:0] held_bytes[3];
    int unsigned       held_count;
    code_unit_t        expected_units[$];
    code_unit_t        step_units[$];
    int unsigned       errors;
    int unsigned       bytes_taken;
    int unsigned       units_checked;
    int unsigned       replays;

    function new();
      emit_utf32    = 1'b0;
      bytes_needed  = '0;
      code_accum    = '0;
      held_count    = 0;
      errors        = 0;
      bytes_taken   = 0;
      units_checked = 0;
      replays       = 0;
    endfunction

    function int unsigned lead_length(logic [BYTE_W-1:0] b);
      if (b[7] == 1'b0) return 1;
      if (b[7:5] == 3'b110) return 2;
      if (b[7:4] == 4'b1110) return 3;
      if (b[7:3] == 5'b11110) return 4;
      return 0;
    endfunction

    function int unsigned lead_payload(logic [BYTE_W-1:0] b, int unsigned n);
      if (n == 1) return b & 8'h7F;
      if (n == 2) return b & 8'h1F;
      if (n == 3) return b & 8'h0F;
      return b & 8'h07;
    endfunction

    function void push_unit(int unsigned v);
      code_unit_t u;
      if (step_units.size() < 3) begin
        u.unit = v[UNIT_W-1:0];
        u.last = 1'b0;
        step_units.push_back(u);
      end
    endfunction

    // Split plane 1 and above into a surrogate pair unless whole code points are sent
    function void push_code_point(int unsigned cp);
      int unsigned r;
      cp = cp & 32'h1F_FFFF;
      if (emit_utf32 || cp < 32'h1_0000) begin
        push_unit(cp);
      end else begin
        r = cp - 32'h1_0000;
        push_unit(((r >> 10) + 32'hD800) & 32'hFFFF);
        push_unit(((r & 32'h3FF) + 32'hDC00) & 32'hFFFF);
      end
    endfunction

    // Decode the held bytes again as fresh leads, skipping incomplete sequences
    function void replay_held();
      int unsigned i;
      int unsigned n;
      int unsigned j;
      int unsigned cp;
      i = 0;
      while (i < held_count) begin
        n = lead_length(held_bytes[i]);
        if (n == 0 || n > held_count - i) begin
          i++;
        end else begin
          cp = lead_payload(held_bytes[i], n);
          for (j = 1; j < n; j++) cp = (cp << 6) | (held_bytes[i + j] & 8'h3F);
          push_code_point(cp);
          i += n;
        end
      end
    endfunction

    function void note_byte(logic [BYTE_W-1:0] b, logic last);
      int unsigned n;
      step_units.delete();
      bytes_taken++;
      if (bytes_needed == 0) begin
        n = lead_length(b);
        if (n == 1) begin
          push_code_point(b);
        end else if (n > 1) begin
          code_accum   = UNIT_W'(lead_payload(b, n));
          bytes_needed = 2'(n - 1);
          held_count   = 0;
        end
      end else begin
        code_accum = {code_accum[UNIT_W-7:0], b[5:0]};
        if (held_count < 3) begin
          held_bytes[held_count] = b;
          held_count++;
        end
        bytes_needed = bytes_needed - 2'd1;
        if (bytes_needed == 0) begin
          push_code_point(code_accum);
          held_count = 0;
        end
      end
      if (last) begin
        if (bytes_needed != 0) begin
          replays++;
          replay_held();
        end
        bytes_needed = 0;
        held_count   = 0;
        code_accum   = '0;
      end
      if (step_units.size() > 0) step_units[step_units.size() - 1].last = 1'b1;
      foreach (step_units[i]) expected_units.push_back(step_units[i]);
    endfunction

    function void check_unit(logic [M_DATA_W-1:0] data, logic last);
      code_unit_t want;
      units_checked++;
      if (expected_units.size() == 0) begin
        errors++;
        $display("%0t: unit with none due: expected nothing, actual unit %h last %b",
                 $time, data[UNIT_W-1:0], last);
        return;
      end
      want = expected_units.pop_front();
      if (data[UNIT_W-1:0] !== want.unit) begin
        errors++;
        $display("%0t: code_unit mismatch: expected %h, actual %h",
                 $time, want.unit, data[UNIT_W-1:0]);
      end
      if (last !== want.last) begin
        errors++;
        $display("%0t: last_of_run mismatch: expected %b, actual %b", $time, want.last, last);
      end
      if (data[M_DATA_W-1:UNIT_W] !== '0) begin
        errors++;
        $display("%0t: tdata padding mismatch: expected 0, actual %b",
                 $time, data[M_DATA_W-1:UNIT_W]);
      end
    endfunction

    function int unsigned pending();
      return expected_units.size();
    endfunction
  endclass

  logic                clk;
  logic                rst;
  logic                s_tvalid;
  logic                s_tready;
  logic [S_DATA_W-1:0] s_tdata;   // [7:0] in_byte
  logic                s_tlast;   // last_byte
  logic                m_tvalid;
  logic                m_tready;
  logic [M_DATA_W-1:0] m_tdata;   // [20:0] code_unit, [23:21] zero
  logic                m_tlast;   // last_of_run
  logic                psel;
  logic                penable;
  logic                pwrite;
  logic [APB_AW-1:0]   paddr;
  logic [APB_DW-1:0]   pwdata;
  logic [APB_DW-1:0]   prdata;
  logic                pready;

  code_unit_tracker units_model;
  bit               sender_gaps;
  bit               receiver_stalls;
  bit               hold_request;
  bit               hold_done;
  int unsigned      items_sent;
  int unsigned      cycle_count;

  utf8_to_utf16_transcoder uut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Bound the run
  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("%0t: timeout after %0d cycles", $time, CYCLE_LIMIT);
    $display("tb: FAIL");
    $finish;
  end

  // Note each accepted byte, then check each accepted word
  always @(posedge clk) begin
    if (rst === 1'b0) begin
      if (s_tvalid && s_tready) units_model.note_byte(s_tdata, s_tlast);
      if (m_tvalid && m_tready) units_model.check_unit(m_tdata, m_tlast);
    end
  end

  // Drive the receiver: random stalls, plus one long hold on request
  initial begin
    m_tready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_request) begin
        m_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_request = 1'b0;
        m_tready <= 1'b1;
      end else if (receiver_stalls && $urandom_range(0, 4) == 0) begin
        m_tready <= 1'b0;
        repeat ($urandom_range(1, 15)) @(posedge clk);
        m_tready <= 1'b1;
      end else begin
        m_tready <= 1'b1;
      end
    end
  end

  // Offer one byte and hold it until the block takes it
  task automatic send_byte(input logic [BYTE_W-1:0] b, input logic last);
    if (sender_gaps && $urandom_range(0, 3) == 0) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 15)) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= b;
    s_tlast  <= last;
    do @(posedge clk); while (s_tready !== 1'b1);
    items_sent++;
  endtask

  // Stop offering bytes and wait until every unit has left
  task automatic drain();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (units_model.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Write emit_utf32, then read it back in a second back-to-back transfer
  task automatic write_emit_utf32(input logic value);
    logic [APB_DW-1:0] readback;
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= REG_EMIT_UTF32;
    pwdata  <= {{(APB_DW-1){1'b0}}, value};
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (pready !== 1'b1);
    units_model.emit_utf32 = value;
    pwrite  <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (pready !== 1'b1);
    readback = prdata;
    psel    <= 1'b0;
    penable <= 1'b0;
    if (readback !== {{(APB_DW-1){1'b0}}, value}) begin
      units_model.errors++;
      $display("%0t: emit_utf32 readback mismatch: expected %h, actual %h",
               $time, {{(APB_DW-1){1'b0}}, value}, readback);
    end
  endtask

  function automatic logic [BYTE_W-1:0] random_lead(int unsigned len);
    if (len == 2) return 8'hC0 | 8'($urandom_range(0, 31));
    if (len == 3) return 8'hE0 | 8'($urandom_range(0, 15));
    return 8'hF0 | 8'($urandom_range(0, 7));
  endfunction

  // Send one random sequence: mostly well formed, some noise and cut-off strings
  task automatic send_random_sequence();
    int unsigned       kind;
    int unsigned       len;
    int unsigned       sent;
    bit                cut_off;
    logic [BYTE_W-1:0] seq[4];
    logic              last;
    kind    = $urandom_range(0, 9);
    cut_off = 1'b0;
    len     = 1;
    case (kind)
      0, 1, 2: begin
        seq[0] = 8'($urandom_range(0, 127));
      end
      3: len = 2;
      4: len = 3;
      5, 6: len = 4;
      7: begin
        seq[0] = $urandom_range(0, 1) ? (8'h80 | 8'($urandom_range(0, 63)))
                                      : (8'hF8 | 8'($urandom_range(0, 7)));
      end
      8: begin
        seq[0] = 8'($urandom_range(0, 255));
      end
      default: begin
        len     = $urandom_range(3, 4);
        cut_off = 1'b1;
      end
    endcase
    if (len > 1) begin
      seq[0] = random_lead(len);
      for (int i = 1; i < len; i++) begin
        seq[i] = cut_off ? 8'($urandom_range(0, 255)) : (8'h80 | 8'($urandom_range(0, 63)));
      end
    end
    sent = cut_off ? $urandom_range(2, len - 1) : len;
    for (int i = 0; i < sent; i++) begin
      last = cut_off ? (i == sent - 1) : ($urandom_range(0, 15) == 0);
      send_byte(seq[i], last);
    end
  endtask

  initial begin
    units_model     = new();
    sender_gaps     = 1'b0;
    receiver_stalls = 1'b0;
    hold_request    = 1'b0;
    hold_done       = 1'b0;
    items_sent      = 0;
    rst      <= 1'b1;
    s_tvalid <= 1'b0;
    s_tdata  <= '0;
    s_tlast  <= 1'b0;
    psel     <= 1'b0;
    penable  <= 1'b0;
    pwrite   <= 1'b0;
    paddr    <= '0;
    pwdata   <= '0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed strings in UTF-16 mode
    write_emit_utf32(1'b0);
    sender_gaps     = 1'b1;
    receiver_stalls = 1'b1;
    send_byte(8'h00, 1'b0);
    send_byte(8'h7F, 1'b0);
    // three-byte euro sign
    send_byte(8'hE2, 1'b0);
    send_byte(8'h82, 1'b0);
    send_byte(8'hAC, 1'b0);
    // plane 1 code point as a surrogate pair
    send_byte(8'hF0, 1'b0);
    send_byte(8'h9F, 1'b0);
    send_byte(8'h98, 1'b0);
    send_byte(8'h80, 1'b0);
    // invalid leads are skipped
    send_byte(8'h80, 1'b0);
    send_byte(8'hFF, 1'b0);
    // ASCII byte taken as a continuation byte
    send_byte(8'hC3, 1'b0);
    send_byte(8'h41, 1'b0);
    // string cut off: held ASCII bytes replayed
    send_byte(8'hF0, 1'b0);
    send_byte(8'h41, 1'b0);
    send_byte(8'h42, 1'b1);
    // string cut off: held two-byte sequence replayed
    send_byte(8'hF0, 1'b0);
    send_byte(8'hC3, 1'b0);
    send_byte(8'hA9, 1'b1);
    // string cut off: incomplete held sequence and stray byte give nothing
    send_byte(8'hF0, 1'b0);
    send_byte(8'hE2, 1'b0);
    send_byte(8'h82, 1'b1);
    drain();

    // Largest encodable value in UTF-32 mode
    write_emit_utf32(1'b1);
    send_byte(8'hF7, 1'b0);
    send_byte(8'hBF, 1'b0);
    send_byte(8'hBF, 1'b0);
    send_byte(8'hBF, 1'b1);
    drain();

    // Random strings in UTF-16 mode, with one long output hold
    write_emit_utf32(1'b0);
    while (items_sent < 110) begin
      if (!hold_done && items_sent >= 40) begin
        hold_request = 1'b1;
        hold_done    = 1'b1;
      end
      send_random_sequence();
    end
    drain();

    // Random strings in UTF-32 mode
    write_emit_utf32(1'b1);
    while (items_sent < 200) send_random_sequence();
    drain();

    // Back-to-back traffic in UTF-16 mode, no idling on either side
    write_emit_utf32(1'b0);
    sender_gaps     = 1'b0;
    receiver_stalls = 1'b0;
    while (items_sent < 270) send_random_sequence();
    drain();

    if (units_model.pending() != 0) begin
      units_model.errors++;
      $display("%0t: units still due at end: expected 0, actual %0d",
               $time, units_model.pending());
    end

    $display("tb: %0d bytes taken, %0d code units checked, %0d strings cut off mid-sequence",
             units_model.bytes_taken, units_model.units_checked, units_model.replays);
    $display("tb: covered UTF-16 and UTF-32 modes, invalid leads and a long output hold");
    if (units_model.errors == 0) begin
      $display("tb: PASS");
    end else begin
      $display("tb: FAIL");
    end
    $finish;
  end

endmodule
